[src/cfrq_pkg.sv]
package cfrq_pkg;

  // Fixed field widths of one frame.
  localparam int ID_W      = 29;
  localparam int LEN_W     = 4;
  localparam int PAYLOAD_W = 64;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_DEPTH         = 16;
  localparam int DEFAULT_PAYLOAD_BYTES = 8;

  // Operation codes carried by a command transaction.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // Status codes returned with every response transaction.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Memory access strobes from the controller.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Response register contents from the controller.
  typedef struct packed {
    logic    valid;
    status_t status;
    logic    popped;
  } rsp_ctl_t;

endpackage

[src/cfrq_ifs.sv]
// Command channel: one push, pop or clear per transaction.
interface cfrq_cmd_if
  import cfrq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic                 drop;
  logic [ID_W-1:0]      frame_id;
  logic [LEN_W-1:0]     frame_len;
  logic [PAYLOAD_W-1:0] frame_payload;

  modport source (output valid, kind, drop, frame_id, frame_len, frame_payload,
                  input ready);
  modport sink (input valid, kind, drop, frame_id, frame_len, frame_payload,
                output ready);
endinterface

// Response channel: one result per command.
interface cfrq_rsp_if
  import cfrq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      out_id;
  logic [LEN_W-1:0]     out_len;
  logic [PAYLOAD_W-1:0] out_payload;

  modport source (output valid, status, out_id, out_len, out_payload,
                  input ready);
  modport sink (input valid, status, out_id, out_len, out_payload,
                output ready);
endinterface

[src/can_frame_ring_queue_unit.sv]
// Ring queue of CAN frames (identifier, length, up to PAYLOAD_BYTES payload bytes) held in a
// DEPTH-entry synchronous memory with one write and one read port. The response to each command
// transaction (push, pop or clear) appears in the output register on the following cycle; a pop
// reads the frame memory at the acceptance edge, and the registered read port delivers the frame
// together with that response. Commands are taken one per cycle as long as the response side
// keeps up. The memory needs no clearing after reset: only slots written since reset are ever
// read. A push onto a full ring with drop set is refused with status full; with drop clear it
// overwrites the oldest frame.
module can_frame_ring_queue_unit
  import cfrq_pkg::*;
#(
  parameter int DEPTH         = DEFAULT_DEPTH,
  parameter int PAYLOAD_BYTES = DEFAULT_PAYLOAD_BYTES
) (
  input logic       clk,
  input logic       rst,
  cfrq_cmd_if.sink  cmd,
  cfrq_rsp_if.source rsp
);

  localparam int PTR_W = $clog2(DEPTH);

  mem_ctl_t             mem_ctl;
  rsp_ctl_t             rsp_ctl;
  logic [PTR_W-1:0]     wr_addr;
  logic [PTR_W-1:0]     rd_addr;
  logic [ID_W-1:0]      rd_id;
  logic [LEN_W-1:0]     rd_len;
  logic [PAYLOAD_W-1:0] rd_payload;

  // Pointer control and response register.
  cfrq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .kind      (cmd.kind),
    .drop      (cmd.drop),
    .rsp_ready (rsp.ready),
    .rsp_ctl   (rsp_ctl),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  // Frame storage.
  cfrq_frame_mem #(
    .DEPTH         (DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .wr_id      (cmd.frame_id),
    .wr_len     (cmd.frame_len),
    .wr_payload (cmd.frame_payload),
    .rd_id      (rd_id),
    .rd_len     (rd_len),
    .rd_payload (rd_payload)
  );

  // Frame fields are shown only for a successful pop, zero otherwise.
  assign rsp.valid       = rsp_ctl.valid;
  assign rsp.status      = rsp_ctl.status;
  assign rsp.out_id      = rsp_ctl.popped ? rd_id : '0;
  assign rsp.out_len     = rsp_ctl.popped ? rd_len : '0;
  assign rsp.out_payload = rsp_ctl.popped ? rd_payload : '0;

endmodule

[src/cfrq_frame_mem.sv]
module cfrq_frame_mem
  import cfrq_pkg::*;
#(
  parameter int DEPTH         = DEFAULT_DEPTH,
  parameter int PAYLOAD_BYTES = DEFAULT_PAYLOAD_BYTES
) (
  input  logic                     clk,
  input  mem_ctl_t                 ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [ID_W-1:0]          wr_id,
  input  logic [LEN_W-1:0]         wr_len,
  input  logic [PAYLOAD_W-1:0]     wr_payload,
  output logic [ID_W-1:0]          rd_id,
  output logic [LEN_W-1:0]         rd_len,
  output logic [PAYLOAD_W-1:0]     rd_payload
);

  localparam int PAY_W   = 8 * PAYLOAD_BYTES;
  localparam int ENTRY_W = LEN_W + ID_W + PAY_W;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [LEN_W-1:0]   len_clamped;

  // Lengths beyond the payload capacity are stored as the capacity.
  assign len_clamped = (wr_len > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : wr_len;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {len_clamped, wr_id, wr_payload[PAY_W-1:0]};
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Unpack the entry; payload bytes above the capacity read as zero.
  assign rd_len     = rd_data[ENTRY_W-1 -: LEN_W];
  assign rd_id      = rd_data[PAY_W +: ID_W];
  assign rd_payload = PAYLOAD_W'(rd_data[PAY_W-1:0]);

endmodule

[src/cfrq_ctrl.sv]
module cfrq_ctrl
  import cfrq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic [KIND_W-1:0]        kind,
  input  logic                     drop,
  input  logic                     rsp_ready,
  output rsp_ctl_t                 rsp_ctl,
  output mem_ctl_t                 mem_ctl,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [$clog2(DEPTH)-1:0] rd_addr
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [CNT_W-1:0] wr_cnt, wr_cnt_next;
  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic [CNT_W-1:0] fill;
  logic             full, empty, accept;
  status_t          status_next;
  logic             popped_next;

  // The fill level never exceeds DEPTH, so its top bit alone marks full.
  assign fill  = wr_cnt - rd_cnt;
  assign full  = fill[CNT_W-1];
  assign empty = (fill == '0);

  // A new command is taken whenever the response register is free or draining.
  assign cmd_ready = !rsp_ctl.valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  assign wr_addr = wr_cnt[PTR_W-1:0];
  assign rd_addr = rd_cnt[PTR_W-1:0];

  // Decode the command and work out the pointer updates.
  always_comb begin
    wr_cnt_next = wr_cnt;
    rd_cnt_next = rd_cnt;
    mem_ctl     = '0;
    status_next = ST_OK;
    popped_next = 1'b0;
    if (accept) begin
      unique case (kind_t'(kind))
        KIND_PUSH: begin
          if (full && drop) begin
            status_next = ST_FULL;
          end else begin
            mem_ctl.wr_en = 1'b1;
            wr_cnt_next   = wr_cnt + CNT_W'(1);
            // Overwriting the oldest frame retires it straight away.
            if (full) begin
              rd_cnt_next = rd_cnt + CNT_W'(1);
            end
          end
        end
        KIND_POP: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            mem_ctl.rd_en = 1'b1;
            popped_next   = 1'b1;
            rd_cnt_next   = rd_cnt + CNT_W'(1);
          end
        end
        KIND_CLEAR: begin
          rd_cnt_next = wr_cnt;
        end
        default: begin
        end
      endcase
    end
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_cnt <= '0;
      rd_cnt <= '0;
    end else begin
      wr_cnt <= wr_cnt_next;
      rd_cnt <= rd_cnt_next;
    end
  end

  // Response register: loaded on every accepted command.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_ctl.valid <= 1'b0;
    end else if (accept) begin
      rsp_ctl.valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_ctl.valid <= 1'b0;
    end
    if (accept) begin
      rsp_ctl.status <= status_next;
      rsp_ctl.popped <= popped_next;
    end
  end

  // The ring never holds more frames than it has slots.
  assert property (@(posedge clk) disable iff (rst) fill <= CNT_W'(DEPTH))
    else $error("fill level exceeds ring depth");

  // A refused push leaves both pointers untouched.
  assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_PUSH && drop && full |=> $stable(wr_cnt) && $stable(rd_cnt))
    else $error("refused push moved a pointer");

  // After a clear the ring is empty.
  assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_CLEAR |=> empty)
    else $error("ring not empty after clear");

  // A pop on an empty ring answers empty and reads nothing.
  assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_POP && empty |=>
      rsp_ctl.valid && rsp_ctl.status == ST_EMPTY && !rsp_ctl.popped)
    else $error("pop on empty ring gave wrong response");

  // Memory reads and writes are issued only for accepted commands.
  assert property (@(posedge clk) disable iff (rst)
    (mem_ctl.wr_en || mem_ctl.rd_en) |-> accept && !(mem_ctl.wr_en && mem_ctl.rd_en))
    else $error("memory access without an accepted command");

endmodule

[tb/can_frame_ring_queue_unit_tb.sv]
module can_frame_ring_queue_unit_tb;
  import cfrq_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RING_DEPTH   = DEFAULT_DEPTH;
  localparam int RING_BYTES   = DEFAULT_PAYLOAD_BYTES;
  localparam int SLOT_W       = $clog2(RING_DEPTH);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int MAX_REPORTED = 10;
  localparam int DRAIN_GUARD  = 5000;

  // The one code of the kind field that the block does not define.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Only the low RING_BYTES bytes of a payload are kept.
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_KEEP =
    {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - 8 * RING_BYTES);

  localparam logic [ID_W-1:0]      ID_ALL_ONES  = {ID_W{1'b1}};
  localparam logic [PAYLOAD_W-1:0] PAY_ALL_ONES = {PAYLOAD_W{1'b1}};

  // What one response transaction should carry.
  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      id;
    logic [LEN_W-1:0]     len;
    logic [PAYLOAD_W-1:0] payload;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;

  cfrq_cmd_if cmd ();
  cfrq_rsp_if rsp ();

  can_frame_ring_queue_unit #(
    .DEPTH        (RING_DEPTH),
    .PAYLOAD_BYTES(RING_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // Clock generation.
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Shadow copy of the ring, updated once per accepted command transaction.
  logic [ID_W-1:0]      ring_id      [RING_DEPTH];
  logic [LEN_W-1:0]     ring_len     [RING_DEPTH];
  logic [PAYLOAD_W-1:0] ring_payload [RING_DEPTH];
  logic [CNT_W-1:0]     ring_wr = '0;
  logic [CNT_W-1:0]     ring_rd = '0;

  frame_result_t owed_results[$];

  int mismatch_count = 0;
  int n_commands     = 0;
  int n_stored       = 0;
  int n_overwrites   = 0;
  int n_refused      = 0;
  int n_popped       = 0;
  int n_empty_pops   = 0;
  int n_clears       = 0;
  int n_unused       = 0;

  // Idling controls shared between the stimulus and the response side.
  bit send_gaps_on  = 1'b0;
  bit rsp_stalls_on = 1'b0;
  int rsp_hold_len  = 0;

  // Applies one command to the shadow ring and returns the response it owes.
  function automatic frame_result_t ring_apply(input logic [KIND_W-1:0]    op,
                                               input logic                 drop_full,
                                               input logic [ID_W-1:0]      id,
                                               input logic [LEN_W-1:0]     len,
                                               input logic [PAYLOAD_W-1:0] payload);
    frame_result_t    res;
    logic [CNT_W-1:0]  level;
    logic [SLOT_W-1:0] slot;
    logic              is_full;
    res     = '{status: ST_OK, id: '0, len: '0, payload: '0};
    level   = ring_wr - ring_rd;
    is_full = (level >= CNT_W'(RING_DEPTH));
    case (op)
      KIND_PUSH: begin
        if (is_full && drop_full) begin
          res.status = ST_FULL;
          n_refused++;
        end else begin
          slot               = ring_wr[SLOT_W-1:0];
          ring_id[slot]      = id;
          ring_len[slot]     = (len > LEN_W'(RING_BYTES)) ? LEN_W'(RING_BYTES) : len;
          ring_payload[slot] = payload & PAYLOAD_KEEP;
          ring_wr            = ring_wr + CNT_W'(1);
          // On a full ring the oldest frame gives way to the new one.
          if (is_full) begin
            ring_rd = ring_rd + CNT_W'(1);
            n_overwrites++;
          end
          n_stored++;
        end
      end
      KIND_POP: begin
        if (level == '0) begin
          res.status = ST_EMPTY;
          n_empty_pops++;
        end else begin
          slot        = ring_rd[SLOT_W-1:0];
          res.id      = ring_id[slot];
          res.len     = ring_len[slot];
          res.payload = ring_payload[slot];
          ring_rd     = ring_rd + CNT_W'(1);
          n_popped++;
        end
      end
      KIND_CLEAR: begin
        ring_rd = ring_wr;
        n_clears++;
      end
      default: begin
        n_unused++;
      end
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [PAYLOAD_W-1:0] exp_v,
                               input logic [PAYLOAD_W-1:0] got_v);
    if (mismatch_count < MAX_REPORTED) begin
      $display("Mismatch in %s at %0t: expected 0x%0h, got 0x%0h", what, $time, exp_v, got_v);
    end
    mismatch_count++;
  endtask

  // Predicts on every accepted command and checks every accepted response.
  always @(posedge clk) begin : watch
    frame_result_t want;
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        n_commands++;
        owed_results.push_back(ring_apply(cmd.kind, cmd.drop, cmd.frame_id, cmd.frame_len,
                                          cmd.frame_payload));
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          note_mismatch("status of a response with nothing owed", '0,
                        PAYLOAD_W'(rsp.status));
        end else begin
          want = owed_results.pop_front();
          if (rsp.status !== want.status) begin
            note_mismatch("status", PAYLOAD_W'(want.status), PAYLOAD_W'(rsp.status));
          end
          if (rsp.out_id !== want.id) begin
            note_mismatch("out_id", PAYLOAD_W'(want.id), PAYLOAD_W'(rsp.out_id));
          end
          if (rsp.out_len !== want.len) begin
            note_mismatch("out_len", PAYLOAD_W'(want.len), PAYLOAD_W'(rsp.out_len));
          end
          if (rsp.out_payload !== want.payload) begin
            note_mismatch("out_payload", want.payload, rsp.out_payload);
          end
        end
      end
    end
  end

  // Response side: random stall bursts, or one long hold when a test asks for it.
  initial begin : rsp_side
    int n;
    rsp.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rsp_hold_len > 0) begin
        n            = rsp_hold_len;
        rsp_hold_len = 0;
        rsp.ready <= 1'b0;
        repeat (n) @(negedge clk);
        rsp.ready <= 1'b1;
      end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Offers one command transaction and returns once it has been accepted.
  task automatic send_cmd(input logic [KIND_W-1:0]    op,
                          input logic                 drop_full,
                          input logic [ID_W-1:0]      id,
                          input logic [LEN_W-1:0]     len,
                          input logic [PAYLOAD_W-1:0] payload);
    int gap;
    @(negedge clk);
    if (send_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid         <= 1'b1;
    cmd.kind          <= op;
    cmd.drop          <= drop_full;
    cmd.frame_id      <= id;
    cmd.frame_len     <= len;
    cmd.frame_payload <= payload;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic send_pop();
    send_cmd(KIND_POP, 1'b0, '0, '0, '0);
  endtask

  // Stops offering and waits until every owed response has come back.
  task automatic wait_drain();
    int guard;
    @(negedge clk);
    cmd.valid <= 1'b0;
    guard = 0;
    while (owed_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (owed_results.size() != 0) begin
      $display("%0d responses never arrived", owed_results.size());
      mismatch_count += owed_results.size();
      owed_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // Pop and clear on an empty ring, and the undefined operation code.
  task automatic test_empty_ring();
    send_pop();
    send_cmd(KIND_CLEAR, 1'b1, ID_ALL_ONES, '1, PAY_ALL_ONES);
    send_cmd(KIND_UNUSED, 1'b1, ID_ALL_ONES, '1, PAY_ALL_ONES);
    wait_drain();
  endtask

  // Field extremes, lengths above the limit, a refused push and an overwrite.
  task automatic test_full_ring();
    int i;
    send_cmd(KIND_PUSH, 1'b1, '0, '0, '0);
    send_cmd(KIND_PUSH, 1'b0, ID_ALL_ONES, LEN_W'(RING_BYTES), PAY_ALL_ONES);
    send_cmd(KIND_PUSH, 1'b1, 29'h0AAA_AAAA, 4'd15, 64'h5555_5555_5555_5555);
    send_cmd(KIND_PUSH, 1'b0, 29'h1555_5555, 4'd9, 64'hAAAA_AAAA_AAAA_AAAA);
    for (i = 4; i < RING_DEPTH; i++) begin
      send_cmd(KIND_PUSH, 1'($urandom), ID_W'($urandom), LEN_W'($urandom_range(0, 8)),
               {$urandom, $urandom});
    end
    // Ring is now full: refuse one push, then overwrite the oldest frame.
    send_cmd(KIND_PUSH, 1'b1, 29'h0123_4567, 4'd3, 64'h0102_0304_0506_0708);
    send_cmd(KIND_PUSH, 1'b0, 29'h1765_4321, 4'd8, 64'h8877_6655_4433_2211);
    for (i = 0; i < 3; i++) send_pop();
    send_cmd(KIND_CLEAR, 1'b0, '0, '0, '0);
    send_pop();
    wait_drain();
  endtask

  // Long response hold while commands keep coming, so the block has to stall its input.
  task automatic test_output_backpressure();
    int i;
    send_gaps_on  = 1'b0;
    rsp_stalls_on = 1'b0;
    rsp_hold_len  = 60;
    for (i = 0; i < 12; i++) begin
      send_cmd(KIND_PUSH, 1'b1, ID_W'($urandom), LEN_W'($urandom_range(0, 15)),
               {$urandom, $urandom});
    end
    for (i = 0; i < 12; i++) send_pop();
    wait_drain();
  endtask

  // Random traffic in segments that lean towards filling, draining or neither.
  task automatic test_random_traffic(input int count);
    int                   i;
    int                   lean;
    int                   pick;
    int                   push_pct;
    int                   pop_pct;
    logic [KIND_W-1:0]    op;
    logic [ID_W-1:0]      id;
    logic [LEN_W-1:0]     len;
    logic [PAYLOAD_W-1:0] payload;
    lean = 0;
    for (i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        lean = $urandom_range(0, 2);
        // The closing quarter of the run goes without idling.
        if (i >= count * 3 / 4) begin
          send_gaps_on  = 1'b0;
          rsp_stalls_on = 1'b0;
        end else begin
          send_gaps_on  = ($urandom_range(0, 2) != 0);
          rsp_stalls_on = ($urandom_range(0, 2) != 0);
        end
      end
      push_pct = (lean == 0) ? 70 : (lean == 1) ? 25 : 47;
      pop_pct  = 95 - push_pct;
      pick     = $urandom_range(0, 99);
      if (pick < push_pct) op = KIND_PUSH;
      else if (pick < push_pct + pop_pct) op = KIND_POP;
      else if (pick < 98) op = KIND_CLEAR;
      else op = KIND_UNUSED;

      case ($urandom_range(0, 7))
        0:       id = '0;
        1:       id = ID_ALL_ONES;
        default: id = ID_W'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0) len = LEN_W'($urandom_range(9, 15));
      else len = LEN_W'($urandom_range(0, 8));
      case ($urandom_range(0, 11))
        0:       payload = '0;
        1:       payload = PAY_ALL_ONES;
        default: payload = {$urandom, $urandom};
      endcase
      send_cmd(op, 1'($urandom), id, len, payload);
    end
    wait_drain();
  endtask

  // Reset, then the tests in turn.
  initial begin : run
    rst               = 1'b1;
    cmd.valid         = 1'b0;
    cmd.kind          = KIND_PUSH;
    cmd.drop          = 1'b0;
    cmd.frame_id      = '0;
    cmd.frame_len     = '0;
    cmd.frame_payload = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_empty_ring();
    test_full_ring();
    test_output_backpressure();
    test_random_traffic(800);

    $display("Checked %0d transactions: %0d frames stored (%0d over the oldest), %0d refused",
             n_commands, n_stored, n_overwrites, n_refused);
    $display("as full, %0d popped, %0d empty pops, %0d clears, %0d unused codes; %0d mismatches.",
             n_popped, n_empty_pops, n_clears, n_unused, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a block that stops answering.
  initial begin : watchdog
    #(CLK_PERIOD * 200000);
    $display("Run did not finish in time.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
